/* sv/multi_reader_slot_register_defines.svh */
// ----------------------------------------------------------------------------
// multi_reader_slot_register_defines
// assertion macros shared by the slot register modules
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_SLOT_REGISTER_DEFINES_SVH
`define MULTI_READER_SLOT_REGISTER_DEFINES_SVH

`ifndef SYNTHESIS
// check sampled on clk_i, masked while rst_ni is low
`define MSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check sampled on clk_i, also active during reset
`define MSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MSR_ASSERT(lbl, prop, msg)
`define MSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/msr_pkg.sv */
// ----------------------------------------------------------------------------
// msr_pkg
// shared constants, codes and control types of the slot register
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

  // default sizes
  localparam int MAX_READERS_DEF = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  // fixed port widths
  localparam int OPCODE_W   = 2;
  localparam int RID_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int AID_W      = 3;
  localparam int CFG_W      = 4;

  // active reader count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP      = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RID = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic exec;      // read/register/nop finish, write scans held slots
    logic pick;      // priority pick of the lowest free slot
    logic commit;    // store write value and rotate slots
    logic cfg_open;  // configuration writes accepted
  } msr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_write;
  } msr_stat_t;

endpackage

`default_nettype wire

/* sv/multi_reader_slot_register.sv */
// ----------------------------------------------------------------------------
// multi_reader_slot_register
// single-writer multi-reader register in a ring of reader count plus two slots
// a write steps through exec, pick and commit states before the result strobe,
//   a read, register or nop through exec only; a new item is taken in the
//   strobe cycle, and writes pay for the held-slot scan and the registered
//   lowest-free-slot pick
// the result strobe lasts one cycle and cannot be stalled by the receiver
// reset (async, active low): slots, traces, marks, id count clear, readers 8
// ----------------------------------------------------------------------------
`default_nettype none

module multi_reader_slot_register import msr_pkg::*; #(
  parameter int MAX_READERS = MAX_READERS_DEF,  // 1..8
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF    // 1..32, stored bits per slot
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // item command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [RID_W-1:0]      reader_id_i,
  input  wire logic [VALUE_W-1:0]    write_value_i,
  // results
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [VALUE_W-1:0]         read_value_o,
  output logic [SLOT_IDX_W-1:0]      slot_index_o,
  output logic [AID_W-1:0]           assigned_id_o,
  // active reader count write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  msr_cmd_t  cmd;
  msr_stat_t stat;

  assign cfg_ready_o = cmd.cfg_open;

  // sequencer
  msr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // slots and reader bookkeeping
  msr_dp #(
    .MAX_READERS (MAX_READERS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .reader_id_i   (reader_id_i),
    .write_value_i (write_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .slot_index_o  (slot_index_o),
    .assigned_id_o (assigned_id_o)
  );

endmodule

`default_nettype wire

/* sv/msr_ctrl.sv */
// ----------------------------------------------------------------------------
// msr_ctrl
// sequencer: accepts items and steps the datapath through each operation
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_reader_slot_register_defines.svh"

module msr_ctrl import msr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire msr_stat_t stat_i,
  output msr_cmd_t       cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  // state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  // an item may enter while the previous result is on the ports
  assign busy_o = !((state_q == S_IDLE) || (state_q == S_RESP));
  assign done_o = (state_q == S_RESP);
  assign accept = start_i && !busy_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = stat_i.is_write ? S_PICK : S_RESP;
      end
      S_PICK: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = start_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.pick     = (state_q == S_PICK);
    cmd_o.commit   = (state_q == S_COMMIT);
    cmd_o.cfg_open = (state_q == S_IDLE);
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  `MSR_ASSERT(a_done_one_cycle, done_o |=> !done_o, "result strobe held longer than one cycle")
  `MSR_ASSERT(a_pick_after_write, (state_q == S_PICK) |-> $past(stat_i.is_write), "slot pick without a write")
  `MSR_ASSERT(a_commit_after_pick, (state_q == S_COMMIT) |-> $past(state_q == S_PICK), "commit not preceded by pick")
  `MSR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE) || !rst_ni, "controller not idle after reset")

endmodule

`default_nettype wire

/* sv/msr_dp.sv */
// ----------------------------------------------------------------------------
// msr_dp
// datapath: value slots, reader marks and traces, free slot scan and pick
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_reader_slot_register_defines.svh"

module msr_dp import msr_pkg::*; #(
  parameter int MAX_READERS = MAX_READERS_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire msr_cmd_t              cmd_i,
  output msr_stat_t                  stat_o,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [RID_W-1:0]      reader_id_i,
  input  wire logic [VALUE_W-1:0]    write_value_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [VALUE_W-1:0]         read_value_o,
  output logic [SLOT_IDX_W-1:0]      slot_index_o,
  output logic [AID_W-1:0]           assigned_id_o
);

  localparam int Slots = MAX_READERS + 2;
  localparam int SiW   = $clog2(Slots);
  localparam int CntW  = $clog2(MAX_READERS + 1);

  // configuration and persistent state
  logic [CFG_W-1:0]      cfg_q;
  logic [DATA_WIDTH-1:0] slot_q  [Slots];
  logic [SiW-1:0]        trace_q [MAX_READERS];
  logic [SiW-1:0]        cur_q;
  logic [MAX_READERS-1:0] marks_q;
  logic [CntW-1:0]       cnt_q;

  // captured item and write pipeline
  logic [OPCODE_W-1:0]   op_q;
  logic [RID_W-1:0]      rid_q;
  logic [DATA_WIDTH-1:0] wval_q;
  logic [Slots-1:0]      held_q, held_d;
  logic [SiW-1:0]        pick_q, pick_d;

  // result registers
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [VALUE_W-1:0]    res_rval_q, res_rval_d;
  logic [SLOT_IDX_W-1:0] res_sidx_q, res_sidx_d;
  logic [AID_W-1:0]      res_aid_q, res_aid_d;
  logic                  res_load;

  logic [MAX_READERS-1:0] act;
  logic                   rid_ok;
  logic                   ids_gone;

  assign stat_o.is_write = (op_q == OP_WRITE);
  assign ids_gone        = (cnt_q == CntW'(MAX_READERS));

  // active readers: count clamped to 1..MAX_READERS
  always_comb begin
    for (int j = 0; j < MAX_READERS; j++) begin
      act[j] = (j == 0) || (j < int'(cfg_q));
    end
  end

  // reader id must name an active reader
  always_comb begin
    rid_ok = 1'b0;
    for (int j = 0; j < MAX_READERS; j++) begin
      if (act[j] && (rid_q == RID_W'(j))) rid_ok = 1'b1;
    end
  end

  // held slots: current one and every active reader's trace
  always_comb begin
    for (int s = 0; s < Slots; s++) begin
      held_d[s] = (cur_q == SiW'(s));
      for (int j = 0; j < MAX_READERS; j++) begin
        if (act[j] && (trace_q[j] == SiW'(s))) held_d[s] = 1'b1;
      end
    end
  end

  // lowest free slot
  always_comb begin
    pick_d = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (!held_q[s]) pick_d = SiW'(s);
    end
  end

  // result of the finishing step
  always_comb begin
    res_status_d = ST_OK;
    res_rval_d   = '0;
    res_sidx_d   = '0;
    res_aid_d    = '0;
    res_load     = cmd_i.commit || (cmd_i.exec && (op_q != OP_WRITE));
    if (cmd_i.commit) begin
      res_sidx_d = SLOT_IDX_W'(pick_q);
    end else begin
      case (op_q)
        OP_READ: begin
          if (rid_ok) begin
            res_rval_d[DATA_WIDTH-1:0] = slot_q[cur_q];
            res_sidx_d                 = SLOT_IDX_W'(cur_q);
          end else begin
            res_status_d = ST_BAD_RID;
          end
        end
        OP_REGISTER: begin
          if (ids_gone) begin
            res_status_d = ST_NO_ID;
          end else begin
            res_aid_d = AID_W'(cnt_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_RESET;
      cur_q   <= '0;
      marks_q <= '0;
      cnt_q   <= '0;
      for (int s = 0; s < Slots; s++) slot_q[s] <= '0;
      for (int j = 0; j < MAX_READERS; j++) trace_q[j] <= '0;
    end else begin
      if (cfg_valid_i && cmd_i.cfg_open) cfg_q <= cfg_data_i;
      // read marks the reader, register hands out the next id
      if (cmd_i.exec) begin
        case (op_q)
          OP_READ: begin
            for (int j = 0; j < MAX_READERS; j++) begin
              if (act[j] && (rid_q == RID_W'(j))) marks_q[j] <= 1'b1;
            end
          end
          OP_REGISTER: begin
            if (!ids_gone) cnt_q <= cnt_q + CntW'(1);
          end
          default: begin
          end
        endcase
      end
      // write: store, hand old current slot to marked readers, rotate
      if (cmd_i.commit) begin
        slot_q[pick_q] <= wval_q;
        for (int j = 0; j < MAX_READERS; j++) begin
          if (act[j] && marks_q[j]) trace_q[j] <= cur_q;
        end
        cur_q   <= pick_q;
        marks_q <= '0;
      end
    end
  end

  // item capture, scan and pick stages, results
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      rid_q  <= reader_id_i;
      wval_q <= write_value_i[DATA_WIDTH-1:0];
    end
    if (cmd_i.exec) held_q <= held_d;
    if (cmd_i.pick) pick_q <= pick_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_rval_q   <= res_rval_d;
      res_sidx_q   <= res_sidx_d;
      res_aid_q    <= res_aid_d;
    end
  end

  assign status_o      = res_status_q;
  assign read_value_o  = res_rval_q;
  assign slot_index_o  = res_sidx_q;
  assign assigned_id_o = res_aid_q;

  // checks
  `MSR_ASSERT(a_pick_is_free, cmd_i.commit |-> !held_q[pick_q], "picked slot is still held")
  `MSR_ASSERT(a_cur_in_range, cur_q <= SiW'(Slots - 1), "current slot index beyond slot count")
  `MSR_ASSERT(a_marks_clear_after_write, cmd_i.commit |=> (marks_q == '0), "reader marks not cleared by write")

endmodule

`default_nettype wire

/* tb/tb_multi_reader_slot_register.sv */
// ----------------------------------------------------------------------------
// tb_multi_reader_slot_register
// self-checking bench for the single-writer multi-reader slot register:
// directed tests for reset contents, id hand-out, value extremes, the unused
// opcode, reader range and count clamping, then random read, write, register
// and nop traffic over many reader counts while an in-bench predictor tracks
// slots, traces and marks and every result strobe is compared field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_reader_slot_register import msr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_READERS = MAX_READERS_DEF;
  localparam int NUM_SLOTS   = NUM_READERS + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_ITEMS = 58;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    value;
    logic [SLOT_IDX_W-1:0] slot;
    logic [AID_W-1:0]      id;
  } slot_result_t;

  // dut connections
  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OPCODE_W-1:0]   opcode_i;
  logic [RID_W-1:0]      reader_id_i;
  logic [VALUE_W-1:0]    write_value_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [VALUE_W-1:0]    read_value_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [AID_W-1:0]      assigned_id_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i;

  // predicted register state
  logic [VALUE_W-1:0]    slot_values [NUM_SLOTS];
  logic [SLOT_IDX_W-1:0] reader_trace [NUM_READERS];
  logic [SLOT_IDX_W-1:0] cur_slot;
  logic [NUM_READERS-1:0] read_marks;
  int unsigned           ids_given;
  logic [CFG_W-1:0]      reader_cfg;

  slot_result_t pending_results [$];
  slot_result_t want_res;
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  idle_pct;
  int unsigned  cfg_round;

  multi_reader_slot_register u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .reader_id_i   (reader_id_i),
    .write_value_i (write_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .slot_index_o  (slot_index_o),
    .assigned_id_o (assigned_id_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // effective reader count, out-of-range settings clamp
  function automatic int unsigned live_readers();
    if (reader_cfg < 1) return 1;
    if (reader_cfg > NUM_READERS) return NUM_READERS;
    return int'(reader_cfg);
  endfunction

  // apply one item to the predicted state and return its result
  function automatic slot_result_t slot_reg_step(logic [OPCODE_W-1:0] op,
                                                 logic [RID_W-1:0] rid,
                                                 logic [VALUE_W-1:0] wval);
    slot_result_t res;
    int unsigned  n;
    int unsigned  pick;
    bit           held;
    bit           found;
    res   = '0;
    n     = live_readers();
    pick  = 0;
    found = 1'b0;
    case (op)
      OP_WRITE: begin
        // lowest slot that is neither current nor in an active trace
        for (int s = 0; s < n + 2; s++) begin
          held = (s == cur_slot);
          for (int j = 0; j < n; j++)
            if (reader_trace[j] == s) held = 1'b1;
          if (!held && !found) begin
            pick  = s;
            found = 1'b1;
          end
        end
        slot_values[pick] = wval;
        for (int j = 0; j < n; j++)
          if (read_marks[j]) reader_trace[j] = cur_slot;
        cur_slot   = SLOT_IDX_W'(pick);
        read_marks = '0;
        res.slot   = SLOT_IDX_W'(pick);
      end
      OP_READ: begin
        if (rid >= n) begin
          res.status = ST_BAD_RID;
        end else begin
          read_marks[rid] = 1'b1;
          res.value = slot_values[cur_slot];
          res.slot  = cur_slot;
        end
      end
      OP_REGISTER: begin
        if (ids_given >= NUM_READERS) begin
          res.status = ST_NO_ID;
        end else begin
          res.id = AID_W'(ids_given);
          ids_given++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status %0d value %h slot %0d id %0d",
                   status_o, read_value_o, slot_index_o, assigned_id_o);
      end else begin
        want_res = pending_results.pop_front();
        if (status_o !== want_res.status || read_value_o !== want_res.value ||
            slot_index_o !== want_res.slot || assigned_id_o !== want_res.id) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp status %0d value %h slot %0d id %0d, got %0d %h %0d %0d",
                     want_res.status, want_res.value, want_res.slot, want_res.id,
                     status_o, read_value_o, slot_index_o, assigned_id_o);
        end
      end
    end
  end

  // send one item, with an optional random idle gap first
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [RID_W-1:0] rid,
                           logic [VALUE_W-1:0] wval);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    reader_id_i   <= rid;
    write_value_i <= wval;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_results.push_back(slot_reg_step(op, rid, wval));
    @(negedge clk_i);
  endtask

  // drain all results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // write the active reader count while idle
  task automatic set_readers(logic [CFG_W-1:0] count);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    reader_cfg = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // slot 0 reads back zero after reset
  task automatic test_reset_contents();
    send_item(OP_READ, 3'd0, 32'h0);
  endtask

  // ids 0..7 handed out, then none left
  task automatic test_register_ids();
    for (int k = 0; k <= NUM_READERS; k++)
      send_item(OP_REGISTER, k[RID_W-1:0], $urandom);
  endtask

  // value extremes through write and read
  task automatic test_value_extremes();
    send_item(OP_WRITE, 3'd7, 32'hffff_ffff);
    send_item(OP_READ, 3'd7, 32'h0);
    send_item(OP_WRITE, 3'd0, 32'h0);
    send_item(OP_READ, 3'd0, 32'hffff_ffff);
    send_item(OP_WRITE, 3'd5, 32'ha5a5_5a5a);
  endtask

  // unused opcode leaves everything alone
  task automatic test_unused_opcode();
    send_item(OP_NOP, 3'd7, 32'hffff_ffff);
  endtask

  // readers at or above the active count are rejected
  task automatic test_reader_range();
    set_readers(4'd3);
    send_item(OP_READ, 3'd2, 32'h0);
    send_item(OP_READ, 3'd3, 32'h0);
    send_item(OP_READ, 3'd7, 32'h0);
    send_item(OP_WRITE, 3'd0, 32'h1234_5678);
    send_item(OP_READ, 3'd1, 32'h0);
  endtask

  // zero acts as one reader, fifteen as the maximum
  task automatic test_count_clamp();
    set_readers(4'd0);
    send_item(OP_READ, 3'd1, 32'h0);
    send_item(OP_READ, 3'd0, 32'h0);
    send_item(OP_WRITE, 3'd0, 32'h0f0f_f0f0);
    set_readers(4'd15);
    send_item(OP_READ, 3'd7, 32'h0);
    send_item(OP_WRITE, 3'd0, 32'hdead_beef);
  endtask

  // random read, write, register and nop traffic, reader count changed every chunk
  task automatic test_random_traffic(int unsigned gap_pct, int unsigned count);
    logic [CFG_W-1:0]    cfg_pick [4];
    logic [RID_W-1:0]    rid;
    logic [VALUE_W-1:0]  wval;
    int unsigned         roll;
    cfg_pick = '{4'd1, 4'd8, 4'd0, 4'd15};
    idle_pct = gap_pct;
    for (int k = 0; k < count; k++) begin
      if (k % CHUNK_ITEMS == 0) begin
        set_readers(cfg_round < 4 ? cfg_pick[cfg_round] : 4'($urandom_range(15)));
        cfg_round++;
      end
      roll = $urandom_range(99);
      rid  = RID_W'($urandom_range(7));
      wval = $urandom;
      if ($urandom_range(9) == 0) wval = '0;
      else if ($urandom_range(9) == 0) wval = '1;
      if (roll < 45)
        send_item(OP_READ, 3'($urandom_range(live_readers() - 1)), wval);
      else if (roll < 55)
        send_item(OP_READ, rid, wval);
      else if (roll < 88)
        send_item(OP_WRITE, rid, wval);
      else if (roll < 95)
        send_item(OP_REGISTER, rid, wval);
      else
        send_item(OP_NOP, rid, wval);
    end
    idle_pct = 0;
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = OP_NOP;
    reader_id_i   = '0;
    write_value_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = CFG_RESET;
    error_count   = 0;
    cycle_count   = 0;
    idle_pct      = 0;
    cfg_round     = 0;
    for (int s = 0; s < NUM_SLOTS; s++) slot_values[s] = '0;
    for (int j = 0; j < NUM_READERS; j++) reader_trace[j] = '0;
    cur_slot   = '0;
    read_marks = '0;
    ids_given  = 0;
    reader_cfg = CFG_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_contents();
    test_register_ids();
    test_value_extremes();
    test_unused_opcode();
    test_reader_range();
    test_count_clamp();
    test_random_traffic(28, 232);
    test_random_traffic(79, 232);
    test_random_traffic(0, 232);

    // drain and settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* multi_reader_slot_register.f */
+incdir+sv
sv/msr_pkg.sv
sv/msr_ctrl.sv
sv/msr_dp.sv
sv/multi_reader_slot_register.sv
tb/tb_multi_reader_slot_register.sv
